[src/lrsgd_pkg.sv]
// Package for the LMS regression trainer: widths, register codes, item types
// and the control bundles passed between the top level and its units.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrsgd_pkg;

	// Default parameter values
	localparam int unsigned MAX_FEATURES_DEF = 8;
	localparam int unsigned FRAC_BITS_DEF    = 16;

	// Field and datapath widths
	localparam int unsigned N_FEAT_FIELDS = 8;
	localparam int unsigned FEAT_W        = 16;
	localparam int unsigned WEIGHT_W      = 32;
	localparam int unsigned ERR_W         = 48;
	localparam int unsigned LR_W          = 24;
	localparam int unsigned LR_FRAC       = 24;
	localparam int unsigned USE_W         = 4;
	localparam int unsigned PROD_W        = WEIGHT_W + FEAT_W;
	localparam int unsigned PRED_W        = PROD_W + 4;
	localparam int unsigned GAIN_MAG_W    = 41;
	localparam int unsigned GAIN_W        = GAIN_MAG_W + 1;
	localparam int unsigned UPD_W         = GAIN_W + FEAT_W;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEATURES_IN_USE = 2'd1;
	localparam logic [LR_W-1:0]      LR_RESET            = 24'd167772;
	localparam logic [USE_W-1:0]     USE_RESET           = 4'd8;

	// Largest step magnitude, 2^40
	localparam logic [GAIN_MAG_W-1:0] STEP_CLAMP = {1'b1, {(GAIN_MAG_W-1){1'b0}}};

	typedef struct packed {
		logic                     start_new_run;
		logic signed [FEAT_W-1:0] feature_0;
		logic signed [FEAT_W-1:0] feature_1;
		logic signed [FEAT_W-1:0] feature_2;
		logic signed [FEAT_W-1:0] feature_3;
		logic signed [FEAT_W-1:0] feature_4;
		logic signed [FEAT_W-1:0] feature_5;
		logic signed [FEAT_W-1:0] feature_6;
		logic signed [FEAT_W-1:0] feature_7;
		logic signed [FEAT_W-1:0] target_value;
	} sample_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]    prediction_error;
		logic signed [WEIGHT_W-1:0] weight_0;
		logic signed [WEIGHT_W-1:0] weight_1;
		logic signed [WEIGHT_W-1:0] weight_2;
		logic signed [WEIGHT_W-1:0] weight_3;
		logic signed [WEIGHT_W-1:0] weight_4;
		logic signed [WEIGHT_W-1:0] weight_5;
		logic signed [WEIGHT_W-1:0] weight_6;
		logic signed [WEIGHT_W-1:0] weight_7;
		logic signed [WEIGHT_W-1:0] bias_value;
	} result_t;

	// Lane strobes
	typedef struct packed {
		logic restore;
		logic load;
		logic mul;
		logic upd;
		logic write;
	} lane_ctl_t;

	// Merge tree strobes
	typedef struct packed {
		logic pair;
		logic sum;
	} merge_ctl_t;

	// Step unit strobes
	typedef struct packed {
		logic mul;
		logic gain;
	} step_ctl_t;

endpackage

`default_nettype wire

[src/linear_regression_sgd_update.sv]
// Usage
// LMS linear regression trainer. Each sample item (valid/ready) carries up to
// eight signed integer features, a target and a restart flag; the block
// predicts from its current weights and bias, forms the error and takes one
// gradient step. Each sample yields one result item (valid/ready) with the
// error and the updated weights and bias, all with FRAC_BITS fraction bits.
// Configuration is a write-only port: cfg_write, cfg_index, cfg_data; index 0
// is the learning rate (24 fraction bits), index 1 the feature count.
// A sample passes the product lanes, two tree levels, the split gain
// multiply and the lane update, in that order, before its result is offered.
// One sample is in flight at a time, as the new weights feed the next
// prediction; the next is taken once the result enters the output register.
// The result sits in an output register, so the next sample is taken while
// a stalled result waits; a finished item then waits for the register.
// Reset sets every weight to 1.0, the bias to 0, the learning rate to about
// 0.01 and the feature count to 8; no result is pending.
// Depends on lrsgd_pkg, lrsgd_lane, lrsgd_merge and lrsgd_step.
`timescale 1ns / 1ps
`default_nettype none

module linear_regression_sgd_update #(
	parameter int unsigned MAX_FEATURES = lrsgd_pkg::MAX_FEATURES_DEF,
	parameter int unsigned FRAC_BITS    = lrsgd_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  lrsgd_pkg::sample_t                  sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output lrsgd_pkg::result_t                  result,
	input  logic                                cfg_write,
	input  logic [lrsgd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lrsgd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lrsgd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD1,
		ST_ADD2,
		ST_STEP,
		ST_GAIN,
		ST_UMUL,
		ST_WRITE,
		ST_OUT
	} state_t;

	localparam int unsigned BSUM_W = GAIN_W + 1;
	localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	state_t                     state_q;
	logic [LR_W-1:0]            lr_q;
	logic [USE_W-1:0]           use_q;
	logic [USE_W-1:0]           used_c;
	logic signed [FEAT_W-1:0]   target_q;
	logic signed [WEIGHT_W-1:0] bias_q;
	logic signed [BSUM_W-1:0]   bsum_c;
	logic signed [WEIGHT_W-1:0] bsat_c;
	logic                       result_valid_q;
	result_t                    result_q;
	logic                       accept_c;
	logic                       out_load_c;

	lane_ctl_t                  lane_ctl;
	merge_ctl_t                 merge_ctl;
	step_ctl_t                  step_ctl;

	logic signed [FEAT_W-1:0]   feat_c   [N_FEAT_FIELDS];
	logic signed [WEIGHT_W-1:0] w_all_c  [N_FEAT_FIELDS];
	logic signed [WEIGHT_W-1:0] lane_w   [MAX_FEATURES];
	logic signed [PROD_W-1:0]   lane_p   [MAX_FEATURES];
	logic [MAX_FEATURES-1:0]    active_c;
	logic signed [ERR_W-1:0]    err_c;
	logic signed [GAIN_W-1:0]   gain_c;

	assign accept_c     = sample_valid && sample_ready;
	assign sample_ready = (state_q == ST_IDLE);
	assign out_load_c   = (state_q == ST_OUT) && (!result_valid_q || result_ready);

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= LR_RESET;
			use_q <= USE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LEARNING_RATE:   lr_q  <= cfg_data[LR_W-1:0];
				REG_FEATURES_IN_USE: use_q <= cfg_data[USE_W-1:0];
				default: ;
			endcase
		end
	end

	// Feature count limited to the lanes present
	assign used_c = (use_q > USE_W'(MAX_FEATURES)) ? USE_W'(MAX_FEATURES) : use_q;

	// Strobes for the units
	always_comb begin
		lane_ctl.restore = accept_c && sample.start_new_run;
		lane_ctl.load    = accept_c;
		lane_ctl.mul     = (state_q == ST_MUL);
		lane_ctl.upd     = (state_q == ST_UMUL);
		lane_ctl.write   = (state_q == ST_WRITE);
		merge_ctl.pair   = (state_q == ST_ADD1);
		merge_ctl.sum    = (state_q == ST_ADD2);
		step_ctl.mul     = (state_q == ST_STEP);
		step_ctl.gain    = (state_q == ST_GAIN);
	end

	assign feat_c[0] = sample.feature_0;
	assign feat_c[1] = sample.feature_1;
	assign feat_c[2] = sample.feature_2;
	assign feat_c[3] = sample.feature_3;
	assign feat_c[4] = sample.feature_4;
	assign feat_c[5] = sample.feature_5;
	assign feat_c[6] = sample.feature_6;
	assign feat_c[7] = sample.feature_7;

	// Feature lanes
	for (genvar j = 0; j < MAX_FEATURES; j++) begin : g_lane
		assign active_c[j] = (USE_W'(j) < used_c);

		lrsgd_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl),
			.active  (active_c[j]),
			.feature (feat_c[j]),
			.gain    (gain_c),
			.weight  (lane_w[j]),
			.product (lane_p[j])
		);
	end

	// Weights beyond the lanes read zero
	for (genvar j = 0; j < N_FEAT_FIELDS; j++) begin : g_wout
		if (j < MAX_FEATURES) begin : g_lane_w
			assign w_all_c[j] = lane_w[j];
		end else begin : g_zero_w
			assign w_all_c[j] = '0;
		end
	end

	lrsgd_merge #(
		.MAX_FEATURES (MAX_FEATURES),
		.FRAC_BITS    (FRAC_BITS)
	) u_merge (
		.clk      (clk),
		.ctl      (merge_ctl),
		.products (lane_p),
		.bias     (bias_q),
		.target   (target_q),
		.err      (err_c)
	);

	lrsgd_step u_step (
		.clk  (clk),
		.ctl  (step_ctl),
		.err  (err_c),
		.lr   (lr_q),
		.gain (gain_c)
	);

	// Capture target
	always_ff @(posedge clk) begin
		if (accept_c) begin
			target_q <= sample.target_value;
		end
	end

	// Saturating bias update
	assign bsum_c = BSUM_W'(bias_q) + BSUM_W'(gain_c);
	always_comb begin
		if (bsum_c > BSUM_W'(W_MAX)) begin
			bsat_c = W_MAX;
		end else if (bsum_c < BSUM_W'(W_MIN)) begin
			bsat_c = W_MIN;
		end else begin
			bsat_c = bsum_c[WEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (lane_ctl.restore) begin
			bias_q <= '0;
		end else if (lane_ctl.write) begin
			bias_q <= bsat_c;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready && !out_load_c) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:  if (accept_c) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_ADD1;
				ST_ADD1:  state_q <= ST_ADD2;
				ST_ADD2:  state_q <= ST_STEP;
				ST_STEP:  state_q <= ST_GAIN;
				ST_GAIN:  state_q <= ST_UMUL;
				ST_UMUL:  state_q <= ST_WRITE;
				ST_WRITE: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load_c) begin
						result_valid_q            <= 1'b1;
						result_q.prediction_error <= err_c;
						result_q.weight_0         <= w_all_c[0];
						result_q.weight_1         <= w_all_c[1];
						result_q.weight_2         <= w_all_c[2];
						result_q.weight_3         <= w_all_c[3];
						result_q.weight_4         <= w_all_c[4];
						result_q.weight_5         <= w_all_c[5];
						result_q.weight_6         <= w_all_c[6];
						result_q.weight_7         <= w_all_c[7];
						result_q.bias_value       <= bias_q;
						state_q                   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

[src/lrsgd_lane.sv]
// One feature lane: holds its weight, forms weight*feature for the prediction
// and applies the saturating update weight += gain*feature.
// Depends on lrsgd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrsgd_lane #(
	parameter int unsigned FRAC_BITS = lrsgd_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lrsgd_pkg::lane_ctl_t                   ctl,
	input  logic                                   active,
	input  logic signed [lrsgd_pkg::FEAT_W-1:0]    feature,
	input  logic signed [lrsgd_pkg::GAIN_W-1:0]    gain,
	output logic signed [lrsgd_pkg::WEIGHT_W-1:0]  weight,
	output logic signed [lrsgd_pkg::PROD_W-1:0]    product
);
	import lrsgd_pkg::*;

	localparam int unsigned SUM_W = UPD_W + 1;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE =
		{{(WEIGHT_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	logic signed [FEAT_W-1:0]   x_q;
	logic signed [WEIGHT_W-1:0] weight_q;
	logic signed [PROD_W-1:0]   mul_c;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [UPD_W-1:0]    upd_c;
	logic signed [UPD_W-1:0]    upd_s2;
	logic signed [SUM_W-1:0]    sum_c;
	logic signed [WEIGHT_W-1:0] sat_c;

	// Multipliers for prediction and update
	assign mul_c = weight_q * x_q;
	assign upd_c = gain * x_q;

	// Saturating weight update
	assign sum_c = SUM_W'(weight_q) + SUM_W'(upd_s2);
	always_comb begin
		if (sum_c > SUM_W'(W_MAX)) begin
			sat_c = W_MAX;
		end else if (sum_c < SUM_W'(W_MIN)) begin
			sat_c = W_MIN;
		end else begin
			sat_c = sum_c[WEIGHT_W-1:0];
		end
	end

	// Hold the weight; restore to 1.0 on a new run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_ONE;
		end else if (ctl.restore) begin
			weight_q <= WEIGHT_ONE;
		end else if (ctl.write && active) begin
			weight_q <= sat_c;
		end
	end

	// Capture feature and register both products
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= feature;
		end
		if (ctl.mul) begin
			prod_s1 <= active ? mul_c : '0;
		end
		if (ctl.upd) begin
			upd_s2 <= upd_c;
		end
	end

	assign weight  = weight_q;
	assign product = prod_s1;

endmodule

`default_nettype wire

[src/lrsgd_merge.sv]
// Merge stage: two-level registered adder tree over the lane products plus
// bias, then target minus prediction saturated to the error width.
// Depends on lrsgd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrsgd_merge #(
	parameter int unsigned MAX_FEATURES = lrsgd_pkg::MAX_FEATURES_DEF,
	parameter int unsigned FRAC_BITS    = lrsgd_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  lrsgd_pkg::merge_ctl_t                 ctl,
	input  logic signed [lrsgd_pkg::PROD_W-1:0]   products [MAX_FEATURES],
	input  logic signed [lrsgd_pkg::WEIGHT_W-1:0] bias,
	input  logic signed [lrsgd_pkg::FEAT_W-1:0]   target,
	output logic signed [lrsgd_pkg::ERR_W-1:0]    err
);
	import lrsgd_pkg::*;

	localparam int unsigned NPAIR  = (MAX_FEATURES + 1) / 2;
	localparam int unsigned PAIR_W = PROD_W + 1;
	localparam int unsigned RAW_W  = PRED_W + 1;
	localparam logic signed [ERR_W-1:0] E_MAX = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic signed [ERR_W-1:0] E_MIN = {1'b1, {(ERR_W-1){1'b0}}};

	logic signed [PAIR_W-1:0] pair_c  [NPAIR];
	logic signed [PAIR_W-1:0] pair_s2 [NPAIR];
	logic signed [PRED_W-1:0] pred_c;
	logic signed [RAW_W-1:0]  tgt_c;
	logic signed [RAW_W-1:0]  diff_c;
	logic signed [ERR_W-1:0]  err_s3;

	// First tree level: add neighbouring lanes
	for (genvar k = 0; k < NPAIR; k++) begin : g_pair
		if (2 * k + 1 < MAX_FEATURES) begin : g_two
			assign pair_c[k] = PAIR_W'(products[2*k]) + PAIR_W'(products[2*k+1]);
		end else begin : g_one
			assign pair_c[k] = PAIR_W'(products[2*k]);
		end
	end

	// Second level: pair sums plus bias, then the error
	always_comb begin
		pred_c = PRED_W'(bias);
		for (int k = 0; k < NPAIR; k++) begin
			pred_c = pred_c + PRED_W'(pair_s2[k]);
		end
	end

	assign tgt_c  = RAW_W'(target) <<< FRAC_BITS;
	assign diff_c = tgt_c - RAW_W'(pred_c);

	always_ff @(posedge clk) begin
		if (ctl.pair) begin
			for (int k = 0; k < NPAIR; k++) begin
				pair_s2[k] <= pair_c[k];
			end
		end
		if (ctl.sum) begin
			if (diff_c > RAW_W'(E_MAX)) begin
				err_s3 <= E_MAX;
			end else if (diff_c < RAW_W'(E_MIN)) begin
				err_s3 <= E_MIN;
			end else begin
				err_s3 <= diff_c[ERR_W-1:0];
			end
		end
	end

	assign err = err_s3;

endmodule

`default_nettype wire

[src/lrsgd_step.sv]
// Step unit: gain = sign(err) * round(2*lr*|err| / 2^24), clamped to 2^40.
// The 48x24 product is split into two 24x24 partial products.
// Depends on lrsgd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrsgd_step (
	input  logic                                clk,
	input  lrsgd_pkg::step_ctl_t                ctl,
	input  logic signed [lrsgd_pkg::ERR_W-1:0]  err,
	input  logic [lrsgd_pkg::LR_W-1:0]          lr,
	output logic signed [lrsgd_pkg::GAIN_W-1:0] gain
);
	import lrsgd_pkg::*;

	localparam int unsigned HI_W  = ERR_W - LR_FRAC;
	localparam int unsigned PP_W  = LR_W + LR_FRAC;
	localparam int unsigned TOT_W = PP_W + 2;
	localparam logic [TOT_W-1:0] HALF = TOT_W'(1) << (LR_FRAC - 1);

	logic [ERR_W-1:0]          mag_c;
	logic [HI_W-1:0]           hi_c;
	logic [LR_FRAC-1:0]        lo_c;
	logic [PP_W-1:0]           ph_c;
	logic [PP_W-1:0]           pl_c;
	logic                      neg_s4;
	logic [PP_W-1:0]           ph_s4;
	logic [PP_W-1:0]           pl_s4;
	logic [TOT_W-1:0]          rnd_c;
	logic [TOT_W-1:0]          tot_c;
	logic [GAIN_MAG_W-1:0]     gmag_c;
	logic signed [GAIN_W-1:0]  gpos_c;
	logic signed [GAIN_W-1:0]  gain_s5;

	// Magnitude split into high and low halves
	assign mag_c = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign hi_c  = mag_c[ERR_W-1:LR_FRAC];
	assign lo_c  = mag_c[LR_FRAC-1:0];
	assign ph_c  = hi_c * lr;
	assign pl_c  = lo_c * lr;

	// Recombine with rounding, clamp and apply sign
	assign rnd_c  = ({1'b0, pl_s4, 1'b0} + HALF) >> LR_FRAC;
	assign tot_c  = {1'b0, ph_s4, 1'b0} + rnd_c;
	assign gmag_c = (tot_c > TOT_W'(STEP_CLAMP)) ? STEP_CLAMP : tot_c[GAIN_MAG_W-1:0];
	assign gpos_c = GAIN_W'(gmag_c);

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			neg_s4 <= err[ERR_W-1];
			ph_s4  <= ph_c;
			pl_s4  <= pl_c;
		end
		if (ctl.gain) begin
			gain_s5 <= neg_s4 ? -gpos_c : gpos_c;
		end
	end

	assign gain = gain_s5;

endmodule

`default_nettype wire

[src/lrsgd_checker.sv]
// Port-level checker for the LMS trainer, bound to the top level.
// Depends on lrsgd_pkg and linear_regression_sgd_update.
`timescale 1ns / 1ps
`default_nettype none

module lrsgd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_ready,
	input lrsgd_pkg::sample_t sample,
	input logic               result_valid,
	input logic               result_ready,
	input lrsgd_pkg::result_t result
);

	// Ready drops only when an item is taken
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_ready) |-> $past(sample_valid))
		else $error("sample_ready fell without an accepted item");

	// One item in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample accepted while previous item still in work");

	// A fresh result only appears from a busy block
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_ready))
		else $error("result appeared while block was idle");

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result dropped or changed");

endmodule

bind linear_regression_sgd_update lrsgd_checker u_lrsgd_checker (.*);

`default_nettype wire
